[rtl/core/swps_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding window peak score package
// Shared widths, the job record that travels from front to back, and the
// window-size clamp and slot wrap helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package swps_pkg;

   localparam int MAX_WINDOW = 32;
   localparam int WIN_MIN    = 2;

   localparam int CSR_W   = 6;
   localparam int TIME_W  = 32;
   localparam int MAG_W   = 32;
   localparam int SCORE_W = 34;

   localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
   localparam int SPAN_W  = FILL_W + 1;
   localparam int SUM_W   = MAG_W + $clog2(MAX_WINDOW) + 1;
   localparam int TOTAL_W = SUM_W + 1;
   localparam int ABS_W   = TOTAL_W - 1;
   localparam int DIV_W   = FILL_W;
   localparam int CNT_W   = $clog2(ABS_W);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_W-1:0] WIN_RESET = CSR_W'(10);

   typedef struct packed {
      logic [TIME_W-1:0]         score_time;
      logic signed [TOTAL_W-1:0] total;
      logic [DIV_W-1:0]          divisor;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // Clamp the written window size into the supported range.
   function automatic logic [FILL_W-1:0] eff_window(logic [CSR_W-1:0] ws);
      int v;
      v = int'(ws);
      if (v < WIN_MIN) v = WIN_MIN;
      if (v > MAX_WINDOW) v = MAX_WINDOW;
      return FILL_W'(v);
   endfunction

   // Circular slot arithmetic; both operands stay below MAX_WINDOW.
   function automatic logic [SLOT_W-1:0] wrap_slot(logic [SLOT_W-1:0] base,
                                                   logic [FILL_W-1:0] off);
      logic [SPAN_W-1:0] s;
      s = SPAN_W'(base) + SPAN_W'(off);
      if (s >= SPAN_W'(MAX_WINDOW)) s = s - SPAN_W'(MAX_WINDOW);
      return s[SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/core/sliding_window_peak_score_top.sv]
// ----------------------------------------------------------------------------
// Sliding window peak score top level
// Flow: a request that fills the window is formed into a job by the front
// end, queued, divided bit-serially and loaded into the output register.
// Throughput: one request per cycle while the window fills; once full, every
// request scores and stalls the sender until the queue takes its job.
// Reset: window size 10, window empty; the sample store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_peak_score_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [swps_pkg::TIME_W-1:0]         req_sample_time,
   input  wire logic signed [swps_pkg::MAG_W-1:0]   req_sample_magnitude,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [swps_pkg::TIME_W-1:0]              rsp_score_time,
   output logic signed [swps_pkg::SCORE_W-1:0]      rsp_peak_score,
   input  wire logic                                csr_wr_en,
   input  wire logic [swps_pkg::CSR_W-1:0]          csr_wr_data
);
   import swps_pkg::*;

   logic      job_push;
   logic      job_pop;
   job_type   push_job;
   job_type   head_job;
   qstat_type q_status;

   swps_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample_time      (req_sample_time),
      .req_sample_magnitude (req_sample_magnitude),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .job_push             (job_push),
      .job                  (push_job),
      .q_status             (q_status)
   );

   swps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   swps_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .q_status       (q_status),
      .job_pop        (job_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_score_time (rsp_score_time),
      .rsp_peak_score (rsp_peak_score)
   );

endmodule

`default_nettype wire

[rtl/core/swps_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/swps_front.sv]
// ----------------------------------------------------------------------------
// Sliding window peak score front end
// Accepts samples, keeps the window store and running sum, and forms the
// score numerator of each full window as a job for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module swps_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [swps_pkg::TIME_W-1:0]    req_sample_time,
   input  wire logic signed [swps_pkg::MAG_W-1:0] req_sample_magnitude,
   input  wire logic                           csr_wr_en,
   input  wire logic [swps_pkg::CSR_W-1:0]     csr_wr_data,
   output logic                                job_push,
   output swps_pkg::job_type                   job,
   input  wire swps_pkg::qstat_type            q_status
);
   import swps_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_READ = 3'b010,
      F_CALC = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [CSR_W-1:0]         win_size_ff, win_size_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SLOT_W-1:0]        oldest_ff, oldest_in;

   logic                     accept;
   logic [FILL_W-1:0]        w;
   logic [FILL_W-1:0]        fill_base;
   logic signed [SUM_W-1:0]  sum_base;
   logic [SLOT_W-1:0]        oldest_base;
   logic [SLOT_W-1:0]        wr_slot;
   logic [SLOT_W-1:0]        mid_slot;
   logic [TIME_W+MAG_W-1:0]  mid_entry;
   logic signed [MAG_W-1:0]  mid_mag;
   logic signed [MAG_W-1:0]  old_mag;
   logic signed [TOTAL_W-1:0] prod;

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid && !req_stall;
   assign w         = eff_window(win_size_ff);

   // Drop a window that somehow holds w samples already.
   assign fill_base   = (fill_ff >= w) ? '0 : fill_ff;
   assign sum_base    = (fill_ff >= w) ? '0 : sum_ff;
   assign oldest_base = (fill_ff >= w) ? '0 : oldest_ff;

   assign wr_slot  = wrap_slot(oldest_base, fill_base);
   assign mid_slot = wrap_slot(oldest_ff, w >> 1);

   swps_ram #(.WIDTH(TIME_W + MAG_W), .DEPTH(MAX_WINDOW)) u_mid_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_slot),
      .wr_data ({req_sample_time, req_sample_magnitude}),
      .rd_addr (mid_slot),
      .rd_data (mid_entry)
   );

   swps_ram #(.WIDTH(MAG_W), .DEPTH(MAX_WINDOW)) u_old_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_slot),
      .wr_data (req_sample_magnitude),
      .rd_addr (oldest_ff),
      .rd_data (old_mag)
   );

   assign mid_mag = signed'(mid_entry[MAG_W-1:0]);
   assign prod    = TOTAL_W'(signed'({1'b0, w})) * TOTAL_W'(mid_mag);

   assign job.score_time = mid_entry[TIME_W+MAG_W-1:MAG_W];
   assign job.total      = prod - TOTAL_W'(sum_ff);
   assign job.divisor    = w - FILL_W'(1);

   always_comb begin
      state_in    = state_ff;
      win_size_in = win_size_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      oldest_in   = oldest_ff;
      job_push    = 1'b0;

      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               fill_in   = fill_base + FILL_W'(1);
               sum_in    = sum_base + SUM_W'(req_sample_magnitude);
               oldest_in = oldest_base;
               if (fill_base + FILL_W'(1) >= w) begin
                  state_in = F_READ;
               end
            end
         end
         F_READ: begin
            state_in = F_CALC;
         end
         F_CALC: begin
            // Hand off the job, then retire the oldest sample.
            if (!q_status.full) begin
               job_push  = 1'b1;
               sum_in    = sum_ff - SUM_W'(old_mag);
               oldest_in = wrap_slot(oldest_ff, FILL_W'(1));
               fill_in   = fill_ff - FILL_W'(1);
               state_in  = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         win_size_in = csr_wr_data;
         fill_in     = '0;
         sum_in      = '0;
         oldest_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         win_size_ff <= WIN_RESET;
         fill_ff     <= '0;
         sum_ff      <= '0;
         oldest_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         win_size_ff <= win_size_in;
         fill_ff     <= fill_in;
         sum_ff      <= sum_in;
         oldest_ff   <= oldest_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/swps_queue.sv]
// ----------------------------------------------------------------------------
// Sliding window peak score job queue
// Short FIFO of score jobs between the front end and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module swps_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire swps_pkg::job_type   push_job,
   input  wire logic                pop,
   output swps_pkg::job_type        head_job,
   output swps_pkg::qstat_type      status
);
   import swps_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                             : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                             : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/swps_back.sv]
// ----------------------------------------------------------------------------
// Sliding window peak score back end
// Bit-serial signed division of each job's numerator by w-1, truncated
// toward zero, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swps_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire swps_pkg::job_type               head_job,
   input  wire swps_pkg::qstat_type             q_status,
   output logic                                 job_pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [swps_pkg::TIME_W-1:0]          rsp_score_time,
   output logic signed [swps_pkg::SCORE_W-1:0]  rsp_peak_score
);
   import swps_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_DONE = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [ABS_W-1:0]   quo_ff, quo_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic               neg_ff, neg_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic               out_valid_ff, out_valid_in;
   logic [TIME_W-1:0]  out_time_ff, out_time_in;
   logic signed [SCORE_W-1:0] out_score_ff, out_score_in;

   logic [DIV_W:0]          shifted;
   logic [TOTAL_W-1:0]      abs_total;
   logic [ABS_W-1:0]        signed_quo;
   logic                    out_free;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign shifted    = {rem_ff, quo_ff[ABS_W-1]};
   assign abs_total  = head_job.total[TOTAL_W-1] ? TOTAL_W'(-head_job.total)
                                                 : TOTAL_W'(head_job.total);
   assign signed_quo = neg_ff ? (~quo_ff + ABS_W'(1)) : quo_ff;

   always_comb begin
      state_in     = state_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      time_in      = time_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_time_in  = out_time_ff;
      out_score_in = out_score_ff;
      job_pop      = 1'b0;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               job_pop  = 1'b1;
               quo_in   = abs_total[ABS_W-1:0];
               rem_in   = '0;
               div_in   = head_job.divisor;
               neg_in   = head_job.total[TOTAL_W-1];
               time_in  = head_job.score_time;
               cnt_in   = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            // One quotient bit per cycle, restoring form.
            if (shifted >= {1'b0, div_ff}) begin
               rem_in = DIV_W'(shifted - {1'b0, div_ff});
               quo_in = {quo_ff[ABS_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[DIV_W-1:0];
               quo_in = {quo_ff[ABS_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ABS_W - 1)) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_time_in  = time_ff;
               out_score_in = signed'(signed_quo[SCORE_W-1:0]);
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      neg_ff       <= neg_in;
      time_ff      <= time_in;
      cnt_ff       <= cnt_in;
      out_time_ff  <= out_time_in;
      out_score_ff <= out_score_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_score_time = out_time_ff;
   assign rsp_peak_score = out_score_ff;

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Sliding window peak score testbench
// Drives timestamped magnitude samples through the block under a mix of window
// sizes, sender bursts and receiver stalls. A scoreboard keeps its own copy
// of the window, predicts each score and compares it with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import swps_pkg::*;

   localparam int SETTLE_CYCLES = 60;
   localparam int TIMEOUT_NS    = 12_000_000;
   localparam int RANDOM_ITEMS  = 1800;

   localparam logic signed [MAG_W-1:0] MAG_MAX = {1'b0, {(MAG_W-1){1'b1}}};
   localparam logic signed [MAG_W-1:0] MAG_MIN = {1'b1, {(MAG_W-1){1'b0}}};

   // Window settings swept first: clamped low, odd, full, clamped high.
   localparam logic [CSR_W-1:0] SIZE_SWEEP [9] = '{
      6'd0, 6'd1, 6'd2, 6'd3, 6'd32, 6'd33, 6'd63, 6'd10, 6'd31
   };

   typedef enum int {STALL_NONE, STALL_COIN, STALL_LONG} stall_mode_type;

   typedef struct {
      logic [TIME_W-1:0]         stamp;
      logic signed [SCORE_W-1:0] score;
   } score_entry_type;

   class peak_score_board;
      logic [CSR_W-1:0]        window_reg;
      logic signed [MAG_W-1:0] mags [MAX_WINDOW];
      logic [TIME_W-1:0]       stamps [MAX_WINDOW];
      int                      held;
      longint                  held_sum;
      int                      head;
      score_entry_type         pending [$];
      int                      errors;

      function new();
         window_reg = WIN_RESET;
         empty_store();
         errors = 0;
      endfunction

      function void empty_store();
         held     = 0;
         held_sum = 0;
         head     = 0;
      endfunction

      function void write_window(logic [CSR_W-1:0] value);
         window_reg = value;
         empty_store();
      endfunction

      function void note_sample(logic [TIME_W-1:0] st, logic signed [MAG_W-1:0] sm);
         int              w;
         int              slot;
         int              mid_slot;
         longint          total;
         longint          quotient;
         score_entry_type e;
         w = int'(window_reg);
         if (w < WIN_MIN) w = WIN_MIN;
         if (w > MAX_WINDOW) w = MAX_WINDOW;
         if (held >= w) empty_store();
         slot = (head + held) % MAX_WINDOW;
         mags[slot]   = sm;
         stamps[slot] = st;
         held++;
         held_sum += longint'(sm);
         if (held < w) return;
         mid_slot = (head + w / 2) % MAX_WINDOW;
         // w*mid - sum is the sum of mid minus every other sample
         total    = longint'(w) * longint'(mags[mid_slot]) - held_sum;
         quotient = total / longint'(w - 1);
         e.stamp  = stamps[mid_slot];
         e.score  = SCORE_W'(quotient);
         pending.push_back(e);
         // drop the oldest sample
         held_sum -= longint'(mags[head]);
         head = (head + 1) % MAX_WINDOW;
         held--;
      endfunction

      function void check_score(logic [TIME_W-1:0] st, logic signed [SCORE_W-1:0] sc);
         score_entry_type e;
         if (pending.size() == 0) begin
            $error("score_time: unexpected response, actual %h, peak_score %0d", st, sc);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (st !== e.stamp) begin
            $error("score_time: expected %h, actual %h", e.stamp, st);
            errors++;
         end
         if (sc !== e.score) begin
            $error("peak_score: expected %0d, actual %0d", e.score, sc);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset                = 1'b1;
   logic                      req_valid            = 1'b0;
   logic                      req_stall;
   logic [TIME_W-1:0]         req_sample_time      = '0;
   logic signed [MAG_W-1:0]   req_sample_magnitude = '0;
   logic                      rsp_valid;
   logic                      rsp_stall            = 1'b0;
   logic [TIME_W-1:0]         rsp_score_time;
   logic signed [SCORE_W-1:0] rsp_peak_score;
   logic                      csr_wr_en            = 1'b0;
   logic [CSR_W-1:0]          csr_wr_data          = '0;

   peak_score_board board = new();

   int             burst_left  = 0;
   stall_mode_type stall_mode  = STALL_NONE;
   int             mode_cycles = 0;
   int             stall_run   = 0;
   logic           stall_level = 1'b0;

   sliding_window_peak_score_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample_time      (req_sample_time),
      .req_sample_magnitude (req_sample_magnitude),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_score_time       (rsp_score_time),
      .rsp_peak_score       (rsp_peak_score),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAILED: results differ");
      $finish;
   end

   // Receiver stall pattern: quiet stretches, coin flips and long holds.
   always @(posedge clock) begin
      if (mode_cycles == 0) begin
         stall_mode  = stall_mode_type'($urandom_range(0, 2));
         mode_cycles = $urandom_range(100, 600);
      end
      mode_cycles--;
      if (stall_run == 0) begin
         case (stall_mode)
            STALL_NONE: begin
               stall_level = 1'b0;
               stall_run   = $urandom_range(1, 20);
            end
            STALL_COIN: begin
               stall_level = 1'($urandom_range(0, 1));
               stall_run   = 1;
            end
            default: begin
               stall_level = ~stall_level;
               stall_run   = stall_level ? $urandom_range(1, 30) : $urandom_range(1, 8);
            end
         endcase
      end
      stall_run--;
      rsp_stall <= stall_level;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_score(rsp_score_time, rsp_peak_score);
      end
   end

   task automatic send_sample(input logic [TIME_W-1:0] st, input logic signed [MAG_W-1:0] sm);
      req_valid            <= 1'b1;
      req_sample_time      <= st;
      req_sample_magnitude <= sm;
      do @(posedge clock); while (req_stall);
      board.note_sample(st, sm);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold the sender until every predicted score has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   task automatic write_window(input logic [CSR_W-1:0] value);
      drain_results();
      // a request that scores nothing may still be in the front end
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.write_window(value);
   endtask

   task automatic pace(input int gap_max);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) idle_sender(gap);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
   endtask

   initial begin
      int                      phase_len;
      int                      setting;
      int                      w_eff;
      int                      gap_max;
      int                      random_items;
      int                      phase_idx;
      logic [TIME_W-1:0]       stamp;
      logic signed [MAG_W-1:0] mag;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset window of 10: middle sample at the top, all others at the bottom.
      for (int k = 0; k < 10; k++) begin
         send_sample(k == 5 ? 32'hFFFF_FFFF : TIME_W'(k), k == 5 ? MAG_MAX : MAG_MIN);
      end

      // Size 0 acts as 2: largest negative and positive scores.
      write_window(6'd0);
      send_sample(32'h0000_0000, MAG_MAX);
      send_sample(32'hFFFF_FFFF, MAG_MIN);
      send_sample(32'h0000_0001, MAG_MAX);
      send_sample(32'h8000_0000, 32'sd0);
      send_sample(32'h7FFF_FFFF, -32'sd1);
      send_sample(32'h0000_0002, 32'sd1);

      write_window(6'd1);
      send_sample(32'h0000_0010, 32'sd5);
      send_sample(32'h0000_0011, -32'sd7);

      // Odd window: scores that truncate toward zero.
      write_window(6'd3);
      send_sample(32'h0000_0020, 32'sd1);
      send_sample(32'h0000_0021, 32'sd0);
      send_sample(32'h0000_0022, 32'sd0);
      send_sample(32'h0000_0023, 32'sd5);
      send_sample(32'h0000_0024, -32'sd4);

      random_items = 0;
      phase_idx    = 0;
      stamp        = $urandom;
      while (random_items < RANDOM_ITEMS) begin
         if (phase_idx < 9) begin
            setting = SIZE_SWEEP[phase_idx];
         end else if ($urandom_range(0, 2) == 0) begin
            setting = SIZE_SWEEP[$urandom_range(0, 8)];
         end else begin
            setting = $urandom_range(0, 63);
         end
         write_window(CSR_W'(setting));
         w_eff = setting < WIN_MIN ? WIN_MIN : (setting > MAX_WINDOW ? MAX_WINDOW : setting);
         phase_len = $urandom_range(15, 100) + (w_eff > 12 ? 2 * w_eff : 0);
         case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 4;
            default: gap_max = 20;
         endcase
         burst_left = 0;
         for (int i = 0; i < phase_len; i++) begin
            if (phase_idx == 3 && i == phase_len / 2) drain_results();
            pace(gap_max);
            if ($urandom_range(0, 15) == 0) begin
               stamp = $urandom;
            end else begin
               stamp = stamp + $urandom_range(1, 500);
            end
            case ($urandom_range(0, 7))
               0: mag = MAG_MIN;
               1: mag = MAG_MAX;
               2, 3: mag = int'($urandom_range(0, 64)) - 32;
               default: mag = $urandom;
            endcase
            send_sample(stamp, mag);
            random_items++;
         end
         phase_idx++;
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
